// ===== hw/rtl/mwoa_pkg.sv =====
package mwoa_pkg;

	localparam int VAL_W  = 64;
	localparam int SIZE_W = 7;
	localparam int IN_W   = 160;
	localparam int OUT_W  = 72;

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_SUB = 2'd1;
	localparam logic [1:0] MODE_MUL = 2'd2;

	typedef struct packed {
		logic             neg;
		logic [VAL_W-1:0] mag;
	} operand_t;

	// low w bits set; w of 64 or more sets all 64 bits
	function automatic logic [VAL_W-1:0] low_mask(input logic [SIZE_W-1:0] w);
		logic [VAL_W-1:0] m;
		if (w >= SIZE_W'(VAL_W)) begin
			m = '1;
		end else begin
			m = (VAL_W'(1) << w) - VAL_W'(1);
		end
		return m;
	endfunction

endpackage

// ===== hw/rtl/mixed_width_overflow_alu.sv =====
// Throughput: one beat per cycle while the output is not stalled; four pipeline stages
// (operand decode, add/sub and 32x32 partial products, product merge and select, wrap
// and overflow check).
// A stalled output beat holds the whole pipeline, so nothing is lost or repeated.
// Reset (arst_n low, asynchronous) clears all stage valid bits; data registers are not reset.
module mixed_width_overflow_alu #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// mode[1:0], left_value[65:2], left_size[72:66], left_is_signed[73],
	// right_value[137:74], right_size[144:138], right_is_signed[145],
	// out_size[152:146], out_is_signed[153], zero pad[159:154]
	input  logic [mwoa_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// result_value[63:0], overflow_flag[64], zero pad[71:65]
	output logic [mwoa_pkg::OUT_W-1:0] m_tdata
);

	localparam int VW = mwoa_pkg::VAL_W;
	localparam int SW = mwoa_pkg::SIZE_W;
	localparam int HW = VW / 2;
	localparam logic [SW-1:0] MaxW = SW'(MAX_WIDTH);

	function automatic logic [SW-1:0] clamp_width(input logic [SW-1:0] raw);
		logic [SW-1:0] w;
		if (raw == '0) begin
			w = SW'(1);
		end else if (raw > MaxW) begin
			w = MaxW;
		end else begin
			w = raw;
		end
		return w;
	endfunction

	function automatic mwoa_pkg::operand_t to_operand(input logic [VW-1:0] raw,
			input logic [SW-1:0] w, input logic sgn);
		mwoa_pkg::operand_t op;
		logic [VW-1:0] m;
		logic [VW-1:0] bits;
		m = mwoa_pkg::low_mask(w);
		bits = raw & m;
		op.neg = sgn && ((bits & (VW'(1) << (w - SW'(1)))) != '0);
		op.mag = op.neg ? ((VW'(0) - bits) & m) : bits;
		return op;
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	assign en       = !v_s4 || m_tready;
	assign s_tready = en;

	// input fields
	logic [1:0]    in_mode;
	logic [VW-1:0] in_lval, in_rval;
	logic [SW-1:0] in_lsize, in_rsize, in_osize;
	logic          in_lsgn, in_rsgn, in_osgn;

	assign in_mode  = s_tdata[1:0];
	assign in_lval  = s_tdata[65:2];
	assign in_lsize = s_tdata[72:66];
	assign in_lsgn  = s_tdata[73];
	assign in_rval  = s_tdata[137:74];
	assign in_rsize = s_tdata[144:138];
	assign in_rsgn  = s_tdata[145];
	assign in_osize = s_tdata[152:146];
	assign in_osgn  = s_tdata[153];

	// stage 1: decode operands
	mwoa_pkg::operand_t lop, rop;
	logic [1:0]         mode_s1, mode_s2;
	mwoa_pkg::operand_t a_s1, b_s1;
	logic [SW-1:0]      ow_s1, ow_s2, ow_s3;
	logic               osgn_s1, osgn_s2, osgn_s3;

	always_comb begin
		lop = to_operand(in_lval, clamp_width(in_lsize), in_lsgn);
		rop = to_operand(in_rval, clamp_width(in_rsize), in_rsgn);
		if (in_mode == mwoa_pkg::MODE_SUB && rop.mag != '0) begin
			rop.neg = !rop.neg;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= in_mode;
			a_s1    <= lop;
			b_s1    <= rop;
			ow_s1   <= clamp_width(in_osize);
			osgn_s1 <= in_osgn;
		end
	end

	// stage 2: signed add/sub of magnitudes, partial products
	logic [VW:0]     sum;
	logic [VW-1:0]   as_mag;
	logic            as_neg;
	logic [VW-1:0]   as_mag_s2;
	logic            as_neg_s2, as_ovf_s2, mul_neg_s2;
	logic [VW-1:0]   pp_ll_s2, pp_lh_s2, pp_hl_s2, pp_hh_s2;

	always_comb begin
		sum = {1'b0, a_s1.mag} + {1'b0, b_s1.mag};
		if (a_s1.neg == b_s1.neg) begin
			as_mag = sum[VW-1:0];
			as_neg = a_s1.neg;
		end else if (a_s1.mag >= b_s1.mag) begin
			as_mag = a_s1.mag - b_s1.mag;
			as_neg = a_s1.neg;
		end else begin
			as_mag = b_s1.mag - a_s1.mag;
			as_neg = b_s1.neg;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2    <= mode_s1;
			ow_s2      <= ow_s1;
			osgn_s2    <= osgn_s1;
			as_mag_s2  <= as_mag;
			as_neg_s2  <= as_neg;
			as_ovf_s2  <= (a_s1.neg == b_s1.neg) && sum[VW];
			mul_neg_s2 <= a_s1.neg != b_s1.neg;
			pp_ll_s2   <= VW'(a_s1.mag[HW-1:0])  * VW'(b_s1.mag[HW-1:0]);
			pp_lh_s2   <= VW'(a_s1.mag[HW-1:0])  * VW'(b_s1.mag[VW-1:HW]);
			pp_hl_s2   <= VW'(a_s1.mag[VW-1:HW]) * VW'(b_s1.mag[HW-1:0]);
			pp_hh_s2   <= VW'(a_s1.mag[VW-1:HW]) * VW'(b_s1.mag[VW-1:HW]);
		end
	end

	// stage 3: merge product, select operation
	logic [VW:0]     mid;
	logic [2*VW-1:0] prod;
	logic [VW-1:0]   mag_s3;
	logic            neg_s3, ovf_s3;

	always_comb begin
		mid  = {1'b0, pp_lh_s2} + {1'b0, pp_hl_s2};
		prod = {pp_hh_s2, pp_ll_s2} + ((2*VW)'(mid) << HW);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ow_s3   <= ow_s2;
			osgn_s3 <= osgn_s2;
			case (mode_s2)
				mwoa_pkg::MODE_ADD, mwoa_pkg::MODE_SUB: begin
					mag_s3 <= as_mag_s2;
					neg_s3 <= as_neg_s2;
					ovf_s3 <= as_ovf_s2;
				end
				default: begin
					mag_s3 <= prod[VW-1:0];
					neg_s3 <= mul_neg_s2;
					ovf_s3 <= prod[2*VW-1:VW] != '0;
				end
			endcase
		end
	end

	// stage 4: wrap to result type, range check
	logic          negf;
	logic [VW-1:0] wrapped;
	logic          over_u, at_lim, over_lim;
	logic [VW-1:0] result_s4;
	logic          ovf_s4;

	always_comb begin
		negf     = neg_s3 && (mag_s3 != '0);
		wrapped  = (negf ? (VW'(0) - mag_s3) : mag_s3) & mwoa_pkg::low_mask(ow_s3);
		over_u   = negf || ((mag_s3 & ~mwoa_pkg::low_mask(ow_s3)) != '0);
		at_lim   = mag_s3 == (VW'(1) << (ow_s3 - SW'(1)));
		over_lim = (mag_s3 & ~mwoa_pkg::low_mask(ow_s3 - SW'(1))) != '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_s4 <= wrapped;
			ovf_s4    <= ovf_s3 || (osgn_s3 ? (negf ? (over_lim && !at_lim) : over_lim)
				: over_u);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = {7'd0, ovf_s4, result_s4};

endmodule

// ===== hw/rtl/mwoa_checker.sv =====
module mwoa_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [mwoa_pkg::OUT_W-1:0] m_tdata
);

	logic s_beat;
	assign s_beat = s_tvalid && s_tready;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[mwoa_pkg::OUT_W-1:65] == '0)
		else $error("output pad bits not zero");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(s_beat, 4) && $past(arst_n, 4) && $past(arst_n, 3) && $past(arst_n, 2)
		&& $past(arst_n, 1) && $past(m_tready, 3) && $past(m_tready, 2)
		&& $past(m_tready, 1) |-> m_tvalid)
		else $error("result beat missing after four cycles");

endmodule

bind mixed_width_overflow_alu mwoa_checker u_mwoa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/mixed_width_overflow_alu_checker.sv =====
module mixed_width_overflow_alu_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	// mode, left_value, left_size, left_is_signed, right_value, right_size,
	// right_is_signed, out_size, out_is_signed, zero pad
	input  logic [mwoa_pkg::IN_W-1:0]  s_tdata,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	// result_value, overflow_flag, zero pad
	input  logic [mwoa_pkg::OUT_W-1:0] m_tdata,
	output int                         mismatches,
	output int                         pending
);

	localparam int         VAL_W    = mwoa_pkg::VAL_W;
	localparam int         SIZE_W   = mwoa_pkg::SIZE_W;
	localparam int         OUT_W    = mwoa_pkg::OUT_W;
	localparam logic [1:0] MODE_ADD = mwoa_pkg::MODE_ADD;
	localparam logic [1:0] MODE_SUB = mwoa_pkg::MODE_SUB;

	typedef struct packed {
		logic [5:0]       pad;
		logic             out_is_signed;
		logic [SIZE_W-1:0] out_size;
		logic             right_is_signed;
		logic [SIZE_W-1:0] right_size;
		logic [VAL_W-1:0] right_value;
		logic             left_is_signed;
		logic [SIZE_W-1:0] left_size;
		logic [VAL_W-1:0] left_value;
		logic [1:0]       mode;
	} alu_op_t;

	// {overflow_flag, result_value}
	logic [VAL_W:0] result_q[$];

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	function automatic int unsigned fit_width(input logic [SIZE_W-1:0] raw);
		if (raw == '0) begin
			return 1;
		end
		if (raw > SIZE_W'(VAL_W)) begin
			return VAL_W;
		end
		return 32'(raw);
	endfunction

	function automatic logic [VAL_W-1:0] width_mask(input int unsigned w);
		if (w >= VAL_W) begin
			return '1;
		end
		return (VAL_W'(1) << w) - VAL_W'(1);
	endfunction

	function automatic logic [VAL_W-1:0] split_sign(input logic [VAL_W-1:0] raw,
			input int unsigned w, input logic sgn, output logic neg);
		logic [VAL_W-1:0] v;
		v   = raw & width_mask(w);
		neg = sgn && v[w-1];
		if (neg) begin
			v = (-v) & width_mask(w);
		end
		return v;
	endfunction

	function automatic logic [VAL_W:0] checked_result(input alu_op_t op);
		int unsigned      ow;
		logic             ln, rn, neg, ovf;
		logic [VAL_W-1:0] a, b, mag, bits, lim;
		logic [VAL_W:0]   sum;
		logic [2*VAL_W-1:0] prod;
		ow  = fit_width(op.out_size);
		a   = split_sign(op.left_value, fit_width(op.left_size), op.left_is_signed, ln);
		b   = split_sign(op.right_value, fit_width(op.right_size), op.right_is_signed, rn);
		ovf = 1'b0;
		if (op.mode == MODE_SUB && b != '0) begin
			rn = !rn;
		end
		if (op.mode == MODE_ADD || op.mode == MODE_SUB) begin
			if (ln == rn) begin
				sum = {1'b0, a} + {1'b0, b};
				ovf = sum[VAL_W];
				mag = sum[VAL_W-1:0];
				neg = ln;
			end else if (a >= b) begin
				mag = a - b;
				neg = ln;
			end else begin
				mag = b - a;
				neg = rn;
			end
		end else begin
			prod = {{VAL_W{1'b0}}, a} * {{VAL_W{1'b0}}, b};
			ovf  = |prod[2*VAL_W-1:VAL_W];
			mag  = prod[VAL_W-1:0];
			neg  = ln ^ rn;
		end
		if (mag == '0) begin
			neg = 1'b0;
		end
		bits = (neg ? -mag : mag) & width_mask(ow);
		if (!op.out_is_signed) begin
			if (neg) begin
				ovf = 1'b1;
			end else if (ow < VAL_W && mag >= (VAL_W'(1) << ow)) begin
				ovf = 1'b1;
			end
		end else begin
			lim = VAL_W'(1) << (ow - 1);
			if (neg ? (mag > lim) : (mag >= lim)) begin
				ovf = 1'b1;
			end
		end
		return {ovf, bits};
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		logic [VAL_W:0] exp;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				result_q.push_back(checked_result(alu_op_t'(s_tdata)));
			end
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					report_mismatch($sformatf("result beat %h with nothing pending", m_tdata));
				end else begin
					exp = result_q.pop_front();
					if (m_tdata[VAL_W-1:0] !== exp[VAL_W-1:0]) begin
						report_mismatch($sformatf("result_value %h, want %h",
							m_tdata[VAL_W-1:0], exp[VAL_W-1:0]));
					end
					if (m_tdata[VAL_W] !== exp[VAL_W]) begin
						report_mismatch($sformatf("overflow_flag %b, want %b",
							m_tdata[VAL_W], exp[VAL_W]));
					end
					if (m_tdata[OUT_W-1:VAL_W+1] !== '0) begin
						report_mismatch($sformatf("pad bits %b, want zero",
							m_tdata[OUT_W-1:VAL_W+1]));
					end
				end
			end
			pending = result_q.size();
		end
	end

endmodule

// ===== tb/mixed_width_overflow_alu_tb.sv =====
module mixed_width_overflow_alu_tb;

	localparam int         VAL_W       = mwoa_pkg::VAL_W;
	localparam int         SIZE_W      = mwoa_pkg::SIZE_W;
	localparam int         IN_W        = mwoa_pkg::IN_W;
	localparam int         OUT_W       = mwoa_pkg::OUT_W;
	localparam logic [1:0] MODE_ADD    = mwoa_pkg::MODE_ADD;
	localparam logic [1:0] MODE_SUB    = mwoa_pkg::MODE_SUB;
	localparam logic [1:0] MODE_MUL    = mwoa_pkg::MODE_MUL;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int         RANDOM_OPS  = 600;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	int                mismatches;
	int                pending;
	logic              no_stall = 1'b0;

	always #10 clk = ~clk;

	mixed_width_overflow_alu dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	mixed_width_overflow_alu_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always @(negedge clk) begin
		m_tready <= no_stall || ($urandom_range(0, 99) >= 13);
	end

	function automatic logic [IN_W-1:0] pack_op(input logic [1:0] mode,
			input logic [VAL_W-1:0] lv, input logic [SIZE_W-1:0] ls, input logic lsg,
			input logic [VAL_W-1:0] rv, input logic [SIZE_W-1:0] rs, input logic rsg,
			input logic [SIZE_W-1:0] os, input logic osg);
		return {6'b0, osg, os, rsg, rs, rv, lsg, ls, lv, mode};
	endfunction

	function automatic logic [SIZE_W-1:0] rand_size();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 4) begin
			return '0;
		end
		if (r < 8) begin
			return SIZE_W'($urandom_range(65, 127));
		end
		if (r < 40) begin
			return SIZE_W'(8 * $urandom_range(1, 8));
		end
		return SIZE_W'($urandom_range(1, 64));
	endfunction

	function automatic logic [VAL_W-1:0] rand_value(input logic [SIZE_W-1:0] raw);
		int unsigned      w;
		logic [VAL_W-1:0] msk, top;
		w   = (raw == '0) ? 1 : (raw > SIZE_W'(VAL_W)) ? VAL_W : raw;
		msk = (w >= VAL_W) ? '1 : (VAL_W'(1) << w) - VAL_W'(1);
		top = VAL_W'(1) << (w - 1);
		case ($urandom_range(0, 6))
			0: return {$urandom, $urandom};
			1: return VAL_W'($urandom_range(0, 3));
			2: return '1;
			3: return top;
			4: return top - VAL_W'(1);
			5: return {$urandom, $urandom} & msk;
			default: return {$urandom, $urandom} & (msk >> $urandom_range(0, 8));
		endcase
	endfunction

	task automatic push_op(input logic [IN_W-1:0] d);
		if (!no_stall && $urandom_range(0, 99) < 13) begin
			s_tvalid <= 1'b0;
			s_tdata  <= {$urandom, $urandom, $urandom, $urandom, $urandom};
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	initial begin
		logic [1:0]        mode;
		logic [SIZE_W-1:0] ls, rs, os;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_op(pack_op(MODE_ADD, '1, 64, 0, 1, 64, 0, 64, 0));
		push_op(pack_op(MODE_ADD, 127, 8, 1, 1, 8, 1, 8, 1));
		push_op(pack_op(MODE_ADD, 'h80, 8, 1, 'h80, 8, 1, 16, 1));
		push_op(pack_op(MODE_SUB, 5, 8, 0, 0, 8, 1, 8, 0));
		push_op(pack_op(MODE_SUB, 3, 8, 0, 5, 8, 0, 8, 0));
		push_op(pack_op(MODE_SUB, 3, 8, 0, 5, 8, 0, 8, 1));
		push_op(pack_op(MODE_SUB, 64'h8000_0000_0000_0000, 64, 1, 1, 64, 0, 64, 1));
		push_op(pack_op(MODE_SUB, 0, 8, 1, 0, 8, 1, 8, 1));
		push_op(pack_op(MODE_MUL, '1, 64, 0, '1, 64, 0, 64, 0));
		push_op(pack_op(MODE_MUL, 'h80, 8, 1, 'hff, 8, 1, 8, 1));
		push_op(pack_op(MODE_MUL, 0, 8, 0, 'hff, 8, 1, 8, 0));
		push_op(pack_op(MODE_MUL, 64'h1_0000_0000, 64, 0, 64'h1_0000_0000, 64, 0, 64, 0));
		push_op(pack_op(MODE_MUL, '1, 64, 1, '1, 64, 1, 64, 1));
		push_op(pack_op(MODE_UNUSED, 7, 8, 0, 6, 8, 0, 8, 0));
		// zero and oversized widths, then values at the edge of their width
		push_op(pack_op(MODE_ADD, 1, 0, 1, 1, 0, 1, 0, 1));
		push_op(pack_op(MODE_ADD, '1, 127, 1, 0, 127, 1, 127, 1));
		push_op(pack_op(MODE_ADD, '1, 65, 0, '1, 65, 0, 65, 0));
		push_op(pack_op(MODE_ADD, 'hfff, 12, 0, 1, 12, 0, 12, 0));
		push_op(pack_op(MODE_ADD, 'hffe, 12, 0, 1, 12, 0, 12, 0));
		push_op(pack_op(MODE_ADD, 64'h8000_0000_0000_0000, 64, 1, 0, 64, 0, 64, 1));
		push_op(pack_op(MODE_ADD, 64'h8000_0000_0000_0000, 64, 0, 0, 64, 0, 64, 1));
		push_op(pack_op(MODE_ADD, 1, 1, 1, 0, 1, 0, 1, 1));
		push_op(pack_op(MODE_ADD, 64'hdead_beef_0000_0012, 8, 0,
			64'hffff_ffff_ffff_ff03, 8, 1, 8, 1));

		for (int i = 0; i < RANDOM_OPS; i++) begin
			no_stall = (i >= 250 && i < 400);
			mode = ($urandom_range(0, 99) < 5) ? MODE_UNUSED : 2'($urandom_range(0, 2));
			ls   = rand_size();
			rs   = rand_size();
			os   = rand_size();
			push_op(pack_op(mode, rand_value(ls), ls, 1'($urandom),
				rand_value(rs), rs, 1'($urandom), os, 1'($urandom)));
		end
		no_stall = 1'b0;
		s_tvalid <= 1'b0;

		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("mixed_width_overflow_alu_tb: done, clean");
		end else begin
			$display("mixed_width_overflow_alu_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("mixed_width_overflow_alu_tb: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/mwoa_pkg.sv
hw/rtl/mixed_width_overflow_alu.sv
hw/rtl/mwoa_checker.sv
tb/mixed_width_overflow_alu_checker.sv
tb/mixed_width_overflow_alu_tb.sv
